// ===== hdl/chtab_pkg.sv =====
// Package for the chained hash table: sizes, codes, beat and state types.
`default_nettype none
package chtab_pkg;

  localparam int MaxBuckets  = 64;
  localparam int PoolNodes   = 256;
  localparam int PayloadBits = 64;

  localparam int KeyBits    = 31;
  localparam int CountBits  = 7;
  localparam int BucketBits = $clog2(MaxBuckets);
  localparam int NodeBits   = $clog2(PoolNodes);
  localparam int PtrBits    = NodeBits + 1;
  // Remainder digits processed per cycle and the padded key width
  localparam int ModDigits  = 4;
  localparam int ModSteps   = (KeyBits + ModDigits - 1) / ModDigits;
  localparam int ModKeyBits = ModSteps * ModDigits;
  localparam int ModCntBits = $clog2(ModSteps);

  typedef enum logic [1:0] {
    REQ_SEARCH = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_POOL_FULL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_HEAD_RD,
    S_HEAD_WT,
    S_NODE_RD,
    S_NODE_CMP,
    S_ALLOC,
    S_FILL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [KeyBits-1:0]     member_key;
    logic [PayloadBits-1:0] member_payload;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [PayloadBits-1:0] found_payload;
  } out_beat_t;

endpackage
`default_nettype wire

// ===== hdl/chained_hash_table.sv =====
// Chained hash table: bucket heads, node pool and free-node stack in local RAMs.
//
// Usage: requests arrive on the in channel (in_valid_i / in_stall_o / in_beat_i),
// one result beat per request leaves on the out channel (out_valid_o /
// out_stall_i / out_beat_o). The bucket is member_key modulo bucket_count (zero
// reads as 1, above 64 as 64); the user writes bucket_count through cfg_we_i /
// cfg_wdata_i only while the block is idle, which the block does not enforce.
// One request is worked at a time; in_stall_o stays high from accept until its
// result is loaded into the output register.
// Steps: accept, remainder digits (4 bits a cycle), bucket head read and wait,
// then per chain node visited a node RAM read and a key compare, a further
// read state to see the end of a chain on a miss, an alloc and a fill state
// for an add that allocates, and a done state that loads the result. A clear
// goes from accept straight to the done state.
// Reset empties all chains at once (bucket valid bits), refills the free stack
// in node order (stack valid bits) and sets bucket_count to 13.
// A stalled result waits in the output register; the next request may be
// accepted meanwhile and holds in its final cycle until the register frees up.
`default_nettype none
module chained_hash_table (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [chtab_pkg::CountBits-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire chtab_pkg::in_beat_t   in_beat_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output chtab_pkg::out_beat_t       out_beat_o
);

  localparam int BB = chtab_pkg::BucketBits;
  localparam int NB = chtab_pkg::NodeBits;
  localparam int PB = chtab_pkg::PtrBits;
  localparam int KB = chtab_pkg::KeyBits;
  localparam int DB = chtab_pkg::PayloadBits;
  localparam int CB = chtab_pkg::CountBits;
  localparam int MD = chtab_pkg::ModDigits;
  localparam int MK = chtab_pkg::ModKeyBits;
  localparam logic [PB-1:0] Nil  = PB'(chtab_pkg::PoolNodes);
  localparam logic [PB-1:0] Full = PB'(chtab_pkg::PoolNodes);

  // Memories
  logic [PB-1:0] bucket_mem [chtab_pkg::MaxBuckets];
  logic [KB-1:0] key_mem    [chtab_pkg::PoolNodes];
  logic [DB-1:0] data_mem   [chtab_pkg::PoolNodes];
  logic [PB-1:0] link_mem   [chtab_pkg::PoolNodes];
  logic [NB-1:0] free_mem   [chtab_pkg::PoolNodes];

  logic [chtab_pkg::MaxBuckets-1:0] bucket_vld_q;
  logic [chtab_pkg::PoolNodes-1:0]  free_vld_q;

  chtab_pkg::state_e state_q, state_d;
  logic [CB-1:0] bcount_q;
  logic [1:0]    req_q, req_d;
  logic [MK-1:0] kshift_q, kshift_d;
  logic [KB-1:0] key_q, key_d;
  logic [DB-1:0] pay_q, pay_d;
  logic [BB-1:0] rem_q, rem_d;
  logic [chtab_pkg::ModCntBits-1:0] mcnt_q, mcnt_d;
  logic [PB-1:0] ptr_q, ptr_d, prev_q, prev_d, head_q, head_d;
  logic [PB-1:0] steps_q, steps_d, fc_q, fc_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [DB-1:0] res_pay_q, res_pay_d;
  logic          out_valid_q, out_valid_d;
  chtab_pkg::out_beat_t out_beat_q, out_beat_d;

  // RAM read data
  logic [PB-1:0] head_rd_q;
  logic          head_vld_rd_q;
  logic [KB-1:0] key_rd_q;
  logic [DB-1:0] data_rd_q;
  logic [PB-1:0] link_rd_q;
  logic [NB-1:0] free_rd_q;
  logic          free_vld_rd_q;
  logic [NB-1:0] free_idx_q;

  // RAM controls
  logic          bkt_we, node_we, link_we, free_we, clear_all;
  logic [BB-1:0] bkt_addr;
  logic [PB-1:0] bkt_wdata, link_wdata;
  logic [NB-1:0] node_addr, link_addr, free_addr, free_wdata;
  logic          node_re, free_re, bkt_re;

  logic [CB-1:0] divisor;
  logic [CB-1:0] trial [MD+1];
  logic [NB-1:0] new_node;

  // Saturated bucket count
  always_comb begin
    if (bcount_q == '0) begin
      divisor = CB'(1);
    end else if (bcount_q > CB'(chtab_pkg::MaxBuckets)) begin
      divisor = CB'(chtab_pkg::MaxBuckets);
    end else begin
      divisor = bcount_q;
    end
  end

  // Remainder digits, MSB first
  always_comb begin
    trial[0] = {1'b0, rem_q};
    for (int i = 0; i < MD; i++) begin
      trial[i+1] = {trial[i][CB-2:0], kshift_q[MK-1-i]};
      if (trial[i+1] >= divisor) begin
        trial[i+1] = trial[i+1] - divisor;
      end
    end
  end

  assign new_node = free_vld_rd_q ? free_rd_q : free_idx_q;

  // Sequencer: next state, RAM controls and result
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    kshift_d     = kshift_q;
    key_d        = key_q;
    pay_d        = pay_q;
    rem_d        = rem_q;
    mcnt_d       = mcnt_q;
    ptr_d        = ptr_q;
    prev_d       = prev_q;
    head_d       = head_q;
    steps_d      = steps_q;
    fc_d         = fc_q;
    res_status_d = res_status_q;
    res_pay_d    = res_pay_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_beat_d   = out_beat_q;
    bkt_we       = 1'b0;
    bkt_re       = 1'b0;
    bkt_addr     = rem_q;
    bkt_wdata    = ptr_q;
    node_we      = 1'b0;
    node_re      = 1'b0;
    node_addr    = ptr_q[NB-1:0];
    link_we      = 1'b0;
    link_addr    = prev_q[NB-1:0];
    link_wdata   = link_rd_q;
    free_we      = 1'b0;
    free_re      = 1'b0;
    free_addr    = fc_q[NB-1:0];
    free_wdata   = ptr_q[NB-1:0];
    clear_all    = 1'b0;
    in_stall_o   = (state_q != chtab_pkg::S_IDLE);

    unique case (state_q)
      chtab_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_beat_i.req_type;
          key_d        = in_beat_i.member_key;
          kshift_d     = MK'(in_beat_i.member_key);
          pay_d        = in_beat_i.member_payload;
          rem_d        = '0;
          mcnt_d       = '0;
          res_status_d = chtab_pkg::ST_OK;
          res_pay_d    = '0;
          if (in_beat_i.req_type == chtab_pkg::REQ_CLEAR) begin
            clear_all = 1'b1;
            fc_d      = Full;
            state_d   = chtab_pkg::S_DONE;
          end else begin
            state_d = chtab_pkg::S_MOD;
          end
        end
      end
      chtab_pkg::S_MOD: begin
        rem_d    = trial[MD][BB-1:0];
        kshift_d = kshift_q << MD;
        mcnt_d   = mcnt_q + 1'b1;
        if (mcnt_q == chtab_pkg::ModCntBits'(chtab_pkg::ModSteps - 1)) begin
          state_d = chtab_pkg::S_HEAD_RD;
        end
      end
      chtab_pkg::S_HEAD_RD: begin
        bkt_re  = 1'b1;
        state_d = chtab_pkg::S_HEAD_WT;
      end
      chtab_pkg::S_HEAD_WT: begin
        head_d  = head_vld_rd_q ? head_rd_q : Nil;
        ptr_d   = head_vld_rd_q ? head_rd_q : Nil;
        prev_d  = Nil;
        steps_d = '0;
        state_d = chtab_pkg::S_NODE_RD;
      end
      chtab_pkg::S_NODE_RD: begin
        if (ptr_q[NB] || steps_q == Full) begin
          // Key not in chain
          if (req_q == chtab_pkg::REQ_ADD) begin
            if (fc_q == '0) begin
              res_status_d = chtab_pkg::ST_POOL_FULL;
              state_d      = chtab_pkg::S_DONE;
            end else begin
              state_d = chtab_pkg::S_ALLOC;
            end
          end else begin
            res_status_d = chtab_pkg::ST_NOT_FOUND;
            state_d      = chtab_pkg::S_DONE;
          end
        end else begin
          node_re = 1'b1;
          state_d = chtab_pkg::S_NODE_CMP;
        end
      end
      chtab_pkg::S_NODE_CMP: begin
        if (key_rd_q == key_q) begin
          state_d = chtab_pkg::S_DONE;
          case (req_q)
            chtab_pkg::REQ_SEARCH: res_pay_d = data_rd_q;
            chtab_pkg::REQ_ADD:    res_status_d = chtab_pkg::ST_DUPLICATE;
            default: begin
              // Unlink, then push the node back on the stack
              if (prev_q[NB]) begin
                bkt_we    = 1'b1;
                bkt_wdata = link_rd_q;
              end else begin
                link_we = 1'b1;
              end
              if (fc_q < Full) begin
                free_we = 1'b1;
                fc_d    = fc_q + 1'b1;
              end
            end
          endcase
        end else begin
          prev_d  = ptr_q;
          ptr_d   = link_rd_q;
          steps_d = steps_q + 1'b1;
          state_d = chtab_pkg::S_NODE_RD;
        end
      end
      chtab_pkg::S_ALLOC: begin
        free_re   = 1'b1;
        free_addr = NB'(fc_q - 1'b1);
        fc_d      = fc_q - 1'b1;
        state_d   = chtab_pkg::S_FILL;
      end
      chtab_pkg::S_FILL: begin
        node_we    = 1'b1;
        node_addr  = new_node;
        link_we    = 1'b1;
        link_addr  = new_node;
        link_wdata = head_q;
        bkt_we     = 1'b1;
        bkt_wdata  = {1'b0, new_node};
        state_d    = chtab_pkg::S_DONE;
      end
      chtab_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d              = 1'b1;
          out_beat_d.status        = res_status_q;
          out_beat_d.found_payload = res_pay_q;
          state_d                  = chtab_pkg::S_IDLE;
        end
      end
      default: state_d = chtab_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= chtab_pkg::S_IDLE;
      bcount_q     <= CB'(13);
      fc_q         <= Full;
      out_valid_q  <= 1'b0;
      bucket_vld_q <= '0;
      free_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        bcount_q <= cfg_wdata_i;
      end
      if (clear_all) begin
        bucket_vld_q <= '0;
        free_vld_q   <= '0;
      end else begin
        if (bkt_we) begin
          bucket_vld_q[bkt_addr] <= 1'b1;
        end
        if (free_we) begin
          free_vld_q[free_addr] <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    kshift_q     <= kshift_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    rem_q        <= rem_d;
    mcnt_q       <= mcnt_d;
    ptr_q        <= ptr_d;
    prev_q       <= prev_d;
    head_q       <= head_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_pay_q    <= res_pay_d;
    out_beat_q   <= out_beat_d;
  end

  // Bucket head RAM
  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bucket_mem[bkt_addr] <= bkt_wdata;
    end
    if (bkt_re) begin
      head_rd_q     <= bucket_mem[bkt_addr];
      head_vld_rd_q <= bucket_vld_q[bkt_addr];
    end
  end

  // Node key and data RAMs
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      key_mem[node_addr]  <= key_q;
      data_mem[node_addr] <= pay_q;
    end
    if (node_re) begin
      key_rd_q  <= key_mem[node_addr];
      data_rd_q <= data_mem[node_addr];
    end
  end

  // Node link RAM
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_addr] <= link_wdata;
    end
    if (node_re) begin
      link_rd_q <= link_mem[node_addr];
    end
  end

  // Free-node stack RAM; an unwritten slot holds its own index
  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_addr] <= free_wdata;
    end
    if (free_re) begin
      free_rd_q     <= free_mem[free_addr];
      free_vld_rd_q <= free_vld_q[free_addr];
      free_idx_q    <= free_addr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Checks
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= Full) else $error("free count above pool size");

  a_alloc_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == chtab_pkg::S_ALLOC |-> fc_q != '0) else $error("alloc from empty stack");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("second beat taken");

  a_node_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_re |-> !ptr_q[NB]) else $error("node read at null pointer");

endmodule
`default_nettype wire
